// ===== hw/rtl/pgsg_pkg.sv =====
// Shared types and constants of the polar Gaussian sample generator.
package pgsg_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    localparam logic [27:0] TWO_LN2_Q27 = 28'd186065279;
    localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] NORM_FLOOR  = 64'h1000_0000_0000_0000;

    localparam logic REG_MEAN = 1'b0;
    localparam logic REG_STD  = 1'b1;

    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [63:0] r;
    } pgsg_item_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_NORM,
        B_SQRT,
        B_DIV,
        B_LMUL,
        B_TSQRT,
        B_FMUL1,
        B_FMUL2,
        B_EMIT
    } back_state_t;

endpackage

// ===== hw/rtl/pgsg_front.sv =====
// Front end: accept uniform pairs, form |x|, |y| and r, drop pairs outside the unit disk or at its centre.
module pgsg_front
    import pgsg_pkg::*;
#(
    parameter int UNIFORM_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      uniform_a,
    input  logic [15:0]      uniform_b,
    input  logic [CNT_W-1:0] queue_count,
    output logic             push,
    output pgsg_item_t       push_item
);

    localparam logic [32:0] HALF  = 33'(64'd1 << (UNIFORM_BITS - 1));
    localparam logic [32:0] MASK  = 33'((64'd1 << UNIFORM_BITS) - 64'd1);
    localparam int          SHIFT = 32 - UNIFORM_BITS;

    logic [32:0] ua;
    logic [32:0] ub;
    logic [32:0] da;
    logic [32:0] db;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        accept;
    logic [63:0] r_sum;

    logic        a_valid_reg;
    logic        a_neg_x_reg;
    logic        a_neg_y_reg;
    logic [31:0] a_ax_reg;
    logic [31:0] a_ay_reg;

    logic        b_valid_reg;
    logic        b_neg_x_reg;
    logic        b_neg_y_reg;
    logic [31:0] b_ax_reg;
    logic [31:0] b_ay_reg;
    logic [63:0] b_sqx_reg;
    logic [63:0] b_sqy_reg;

    assign ua = 33'(uniform_a) & MASK;
    assign ub = 33'(uniform_b) & MASK;
    assign da = (ua >= HALF) ? (ua - HALF) : (HALF - ua);
    assign db = (ub >= HALF) ? (ub - HALF) : (HALF - ub);
    assign ax = 32'(da << SHIFT);
    assign ay = 32'(db << SHIFT);

    assign in_ready = (4'(queue_count) + 4'(a_valid_reg) + 4'(b_valid_reg)) < 4'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    assign r_sum = b_sqx_reg + b_sqy_reg;
    assign push  = b_valid_reg && (r_sum != 64'd0) && (r_sum <= ONE_Q62);

    always_comb
    begin
        push_item.neg_x = b_neg_x_reg;
        push_item.neg_y = b_neg_y_reg;
        push_item.ax    = b_ax_reg;
        push_item.ay    = b_ay_reg;
        push_item.r     = r_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_neg_x_reg <= ua < HALF;
        a_neg_y_reg <= ub < HALF;
        a_ax_reg    <= ax;
        a_ay_reg    <= ay;
        b_neg_x_reg <= a_neg_x_reg;
        b_neg_y_reg <= a_neg_y_reg;
        b_ax_reg    <= a_ax_reg;
        b_ay_reg    <= a_ay_reg;
        b_sqx_reg   <= 64'(a_ax_reg) * 64'(a_ax_reg);
        b_sqy_reg   <= 64'(a_ay_reg) * 64'(a_ay_reg);
    end

endmodule

// ===== hw/rtl/pgsg_queue.sv =====
// Short queue of accepted pairs between the front end and the back end.
module pgsg_queue
    import pgsg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pgsg_item_t       push_item,
    input  logic             pop,
    output logic             head_valid,
    output pgsg_item_t       head_item,
    output logic [CNT_W-1:0] count
);

    pgsg_item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_pop;

    assign head_valid = count_reg != '0;
    assign head_item  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/pgsg_back.sv =====
// Back end: iterative normalize, square root, divide, log and scale, then emit two beats.
module pgsg_back
    import pgsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  pgsg_item_t  head_item,
    output logic        pop,
    input  logic [31:0] mean_offset,
    input  logic [23:0] std_scale,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sample,
    output logic        last
);

    back_state_t state_reg, state_next;

    logic [63:0] rn_reg, rn_next;
    logic [31:0] axs_reg, axs_next;
    logic [31:0] ays_reg, ays_next;
    logic [4:0]  e_reg, e_next;
    logic        neg_x_reg, neg_x_next;
    logic        neg_y_reg, neg_y_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] sq_v_reg, sq_v_next;
    logic [63:0] sq_res_reg, sq_res_next;
    logic [63:0] sq_bit_reg, sq_bit_next;
    logic [31:0] m_reg, m_next;
    logic [29:0] frac_reg, frac_next;
    logic [5:0]  k_reg, k_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] rem_x_reg, rem_x_next;
    logic [31:0] rem_y_reg, rem_y_next;
    logic [31:0] nlo_x_reg, nlo_x_next;
    logic [31:0] nlo_y_reg, nlo_y_next;
    logic [31:0] qx_reg, qx_next;
    logic [31:0] qy_reg, qy_next;
    logic [31:0] t_reg, t_next;
    logic        sel_reg, sel_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] v_reg, v_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] sample_reg, sample_next;
    logic        last_reg, last_next;

    logic [63:0] sq_sum;
    logic        sq_take;
    logic [63:0] sq_v_step;
    logic [63:0] sq_res_step;
    logic [63:0] msq;
    logic        m_carry;
    logic [31:0] m_step;
    logic [32:0] tx;
    logic [32:0] ty;
    logic        gex;
    logic        gey;
    logic [35:0] lg;
    logic [36:0] n_val;
    logic [63:0] nstd;
    logic [33:0] sv;
    logic [33:0] ssum;
    logic [31:0] sat;
    logic [5:0]  p_top;
    logic        load_out;

    assign sq_sum      = sq_res_reg + sq_bit_reg;
    assign sq_take     = sq_v_reg >= sq_sum;
    assign sq_v_step   = sq_take ? (sq_v_reg - sq_sum) : sq_v_reg;
    assign sq_res_step = sq_take ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);

    assign msq     = 64'(m_reg) * 64'(m_reg);
    assign m_carry = msq[63];
    assign m_step  = m_carry ? msq[63:32] : msq[62:31];

    assign tx  = {rem_x_reg, nlo_x_reg[31]};
    assign ty  = {rem_y_reg, nlo_y_reg[31]};
    assign gex = tx >= {1'b0, sq_reg};
    assign gey = ty >= {1'b0, sq_reg};

    assign lg    = {6'd62 - k_reg, 30'd0} - {6'd0, frac_reg};
    assign n_val = 37'((prod_reg + 64'h400_0000) >> 27);
    assign nstd  = 64'(n_val) * 64'(std_scale) + 64'h8000_0000;

    assign sv   = (sel_reg ? neg_y_reg : neg_x_reg) ? (34'd0 - 34'(v_reg)) : 34'(v_reg);
    assign ssum = sv + {{2{mean_offset[31]}}, mean_offset};

    always_comb
    begin
        if ($signed(ssum) > 34'sh0_7FFF_FFFF)
        begin
            sat = 32'h7FFF_FFFF;
        end
        else if ($signed(ssum) < -34'sh0_8000_0000)
        begin
            sat = 32'h8000_0000;
        end
        else
        begin
            sat = ssum[31:0];
        end
    end

    always_comb
    begin
        if (rn_reg[62])
        begin
            p_top = 6'd62;
        end
        else if (rn_reg[61])
        begin
            p_top = 6'd61;
        end
        else
        begin
            p_top = 6'd60;
        end
    end

    assign load_out = (state_reg == B_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        rn_next        = rn_reg;
        axs_next       = axs_reg;
        ays_next       = ays_reg;
        e_next         = e_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        cnt_next       = cnt_reg;
        sq_v_next      = sq_v_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        k_next         = k_reg;
        sq_next        = sq_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        nlo_x_next     = nlo_x_reg;
        nlo_y_next     = nlo_y_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        t_next         = t_reg;
        sel_next       = sel_reg;
        prod_next      = prod_reg;
        v_next         = v_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    rn_next    = head_item.r;
                    axs_next   = head_item.ax;
                    ays_next   = head_item.ay;
                    neg_x_next = head_item.neg_x;
                    neg_y_next = head_item.neg_y;
                    e_next     = 5'd0;
                    state_next = B_NORM;
                end
            end
            B_NORM:
            begin
                if (rn_reg < NORM_FLOOR)
                begin
                    rn_next  = rn_reg << 2;
                    axs_next = axs_reg << 1;
                    ays_next = ays_reg << 1;
                    e_next   = e_reg + 5'd1;
                end
                else
                begin
                    case (p_top)
                        6'd62:   m_next = rn_reg[62:31];
                        6'd61:   m_next = rn_reg[61:30];
                        default: m_next = rn_reg[60:29];
                    endcase
                    k_next      = p_top - {e_reg, 1'b0};
                    frac_next   = '0;
                    sq_v_next   = rn_reg;
                    sq_res_next = '0;
                    sq_bit_next = ONE_Q62;
                    cnt_next    = 5'd31;
                    state_next  = B_SQRT;
                end
            end
            B_SQRT:
            begin
                sq_v_next   = sq_v_step;
                sq_res_next = sq_res_step;
                sq_bit_next = sq_bit_reg >> 2;
                if (cnt_reg >= 5'd2)
                begin
                    m_next    = m_step;
                    frac_next = {frac_reg[28:0], m_carry};
                end
                if (cnt_reg == 5'd0)
                begin
                    sq_next    = sq_res_step[31:0];
                    rem_x_next = {1'b0, axs_reg[31:1]};
                    rem_y_next = {1'b0, ays_reg[31:1]};
                    nlo_x_next = {axs_reg[0], 31'd0};
                    nlo_y_next = {ays_reg[0], 31'd0};
                    cnt_next   = 5'd31;
                    state_next = B_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            B_DIV:
            begin
                rem_x_next = gex ? 32'(tx - {1'b0, sq_reg}) : tx[31:0];
                rem_y_next = gey ? 32'(ty - {1'b0, sq_reg}) : ty[31:0];
                nlo_x_next = nlo_x_reg << 1;
                nlo_y_next = nlo_y_reg << 1;
                qx_next    = {qx_reg[30:0], gex};
                qy_next    = {qy_reg[30:0], gey};
                if (cnt_reg == 5'd0)
                begin
                    state_next = B_LMUL;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            B_LMUL:
            begin
                sq_v_next   = (64'(lg) * 64'(TWO_LN2_Q27)) >> 1;
                sq_res_next = '0;
                sq_bit_next = ONE_Q62;
                cnt_next    = 5'd31;
                state_next  = B_TSQRT;
            end
            B_TSQRT:
            begin
                sq_v_next   = sq_v_step;
                sq_res_next = sq_res_step;
                sq_bit_next = sq_bit_reg >> 2;
                if (cnt_reg == 5'd0)
                begin
                    t_next     = sq_res_step[31:0];
                    sel_next   = 1'b0;
                    state_next = B_FMUL1;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            B_FMUL1:
            begin
                prod_next  = 64'(sel_reg ? qy_reg : qx_reg) * 64'(t_reg);
                state_next = B_FMUL2;
            end
            B_FMUL2:
            begin
                v_next     = 32'(nstd >> 32);
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = sat;
                    last_next      = sel_reg;
                    if (sel_reg)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        sel_next   = 1'b1;
                        state_next = B_FMUL1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rn_reg     <= rn_next;
        axs_reg    <= axs_next;
        ays_reg    <= ays_next;
        e_reg      <= e_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        cnt_reg    <= cnt_next;
        sq_v_reg   <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        m_reg      <= m_next;
        frac_reg   <= frac_next;
        k_reg      <= k_next;
        sq_reg     <= sq_next;
        rem_x_reg  <= rem_x_next;
        rem_y_reg  <= rem_y_next;
        nlo_x_reg  <= nlo_x_next;
        nlo_y_reg  <= nlo_y_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        t_reg      <= t_next;
        sel_reg    <= sel_next;
        prod_reg   <= prod_next;
        v_reg      <= v_next;
        sample_reg <= sample_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;

endmodule

// ===== hw/rtl/polar_gaussian_sample_generator_core.sv =====
// Polar Gaussian sample generator: top level with register port, front end, queue and back end.
// Input channel (in_valid/in_ready): one beat carries a pair of uniform words.
// Output channel (out_valid/out_ready): each kept pair gives two beats of sample,
// the second with last high; pairs outside the unit disk or at its centre give no beat.
// Register port: mean_offset at 0x0, std_scale at 0x4; write only while idle.
// While in_ready is high the front end takes one beat per cycle into a two-stage
// pipeline that forms r and drops rejected pairs; up to four kept pairs wait in the queue.
// in_ready drops when queue plus front pipeline hold four pairs.
// The back end works one pair at a time: normalize (two bits a step), a
// 32-step square root that also runs 30 log squarings, a 32-step divide for
// both coordinates, one multiply, a 32-step square root of -2 ln r, then two
// multiply steps and an emit step per sample that waits for a free output register.
// The back end's iterative root and divide steps bound the rate of kept pairs;
// the front end and queue take new pairs while the back end works on one.
// Reset empties the pipeline and queue and restores mean_offset 0, std_scale 1.0.
// A stalled receiver holds the output register; the back end then waits, the
// queue fills, and in_ready falls.
module polar_gaussian_sample_generator_core
    import pgsg_pkg::*;
#(
    parameter int UNIFORM_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] uniform_a,
    input  logic [15:0] uniform_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sample,
    output logic        last
);

    logic [31:0]      mean_offset_reg;
    logic [23:0]      std_scale_reg;
    logic             cfg_write;
    logic             push;
    pgsg_item_t       push_item;
    logic             pop;
    logic             head_valid;
    pgsg_item_t       head_item;
    logic [CNT_W-1:0] queue_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_STD) ? {8'd0, std_scale_reg} : mean_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_offset_reg <= 32'd0;
            std_scale_reg   <= 24'd65536;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MEAN)
            begin
                mean_offset_reg <= pwdata;
            end
            else
            begin
                std_scale_reg <= pwdata[23:0];
            end
        end
    end

    pgsg_front #(
        .UNIFORM_BITS(UNIFORM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .uniform_a  (uniform_a),
        .uniform_b  (uniform_b),
        .queue_count(queue_count),
        .push       (push),
        .push_item  (push_item)
    );

    pgsg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_valid(head_valid),
        .head_item (head_item),
        .count     (queue_count)
    );

    pgsg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .mean_offset(mean_offset_reg),
        .std_scale  (std_scale_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .last       (last)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the polar Gaussian sample generator core.
module tb_top;
    import pgsg_pkg::*;

    typedef struct packed {
        logic [15:0] ua;
        logic [15:0] ub;
    } pair_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } sample_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] uniform_a;
    logic [15:0] uniform_b;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] sample;
    logic        last;

    pair_t   pending_pairs[$];
    sample_t expected_samples[$];
    longint  mean_q16;
    longint unsigned std_q16;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_left;
    int      mismatches;

    polar_gaussian_sample_generator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .uniform_a (uniform_a),
        .uniform_b (uniform_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .last      (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned neg_two_ln(longint unsigned r);
        int              k;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned lg;
        k = 0;
        frac = 0;
        while (k < 63 && (r >> (k + 1)) != 0)
            k++;
        m = (k >= 31) ? (r >> (k - 31)) : (r << (31 - k));
        for (int i = 29; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        lg = (longint'(62 - k) << 30) - frac;
        return lg * longint'(TWO_LN2_Q27);
    endfunction

    function automatic logic [31:0] scale_sample(logic neg, longint unsigned c,
                                                 longint unsigned t);
        longint unsigned n;
        longint unsigned v;
        longint          s;
        n = (c * t + (64'd1 << 26)) >> 27;
        v = (n * std_q16 + (64'd1 << 31)) >> 32;
        s = neg ? -longint'(v) : longint'(v);
        s = s + mean_q16;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return s[31:0];
    endfunction

    task automatic expect_beat(logic [31:0] value, logic is_last);
        sample_t s;
        s.value = value;
        s.last  = is_last;
        expected_samples.insert(expected_samples.size(), s);
    endtask

    task automatic add_pair(logic [15:0] a, logic [15:0] b);
        pair_t p;
        p.ua = a;
        p.ub = b;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    task automatic predict_samples(pair_t p);
        longint          x;
        longint          y;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned r;
        longint unsigned rn;
        longint unsigned sq;
        longint unsigned t;
        int              e;
        x = (longint'(p.ua) - 32768) * 65536;
        y = (longint'(p.ub) - 32768) * 65536;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        r = ax * ax + ay * ay;
        if (r == 0 || r > ONE_Q62)
            return;
        rn = r;
        e = 0;
        while (rn < (64'd1 << 60))
        begin
            rn = rn << 2;
            e++;
        end
        sq = int_sqrt(rn);
        t = int_sqrt(neg_two_ln(r) >> 1);
        expect_beat(scale_sample(x < 0, ((ax << e) << 31) / sq, t), 1'b0);
        expect_beat(scale_sample(y < 0, ((ay << e) << 31) / sq, t), 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            uniform_a <= '0;
            uniform_b <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pair_t p;
                p = pending_pairs.pop_front();
                in_valid  <= 1'b1;
                uniform_a <= p.ua;
                uniform_b <= p.ub;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_samples({uniform_a, uniform_b});
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: sample %h last %b", sample, last);
                end
                else
                begin
                    sample_t s;
                    s = expected_samples.pop_front();
                    if (s.value !== sample || s.last !== last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample exp %h got %h, last exp %b got %b",
                                     s.value, sample, s.last, last);
                    end
                end
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MEAN)
            mean_q16 = longint'(signed'(value));
        else
            std_q16 = 64'(value[23:0]);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_pairs.size() > 0 || in_valid || expected_samples.size() > 0);
        repeat (200) @(negedge clk);
    endtask

    task automatic add_directed();
        add_pair(16'd0, 16'd0);
        add_pair(16'd32768, 16'd32768);
        add_pair(16'd0, 16'd32768);
        add_pair(16'd32768, 16'd0);
        add_pair(16'd65535, 16'd32768);
        add_pair(16'd32768, 16'd65535);
        add_pair(16'd32769, 16'd32768);
        add_pair(16'd32767, 16'd32768);
        add_pair(16'd32768, 16'd32767);
        add_pair(16'd65535, 16'd65535);
        add_pair(16'd0, 16'd65535);
        add_pair(16'd55000, 16'd55000);
        add_pair(16'd10000, 16'd40000);
        add_pair(16'hAAAA, 16'h5555);
        add_pair(16'h5555, 16'hAAAA);
    endtask

    task automatic add_random(int count);
        for (int i = 0; i < count; i++)
            add_pair(16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mean_q16 = 0;
        std_q16 = 65536;
        send_idle_pct = 11;
        recv_idle_pct = 66;
        hold_left = 0;
        mismatches = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        add_directed();
        add_random(250);
        drain();

        write_reg(REG_MEAN, 32'h7FFF_FFFF);
        write_reg(REG_STD, 32'h00FF_FFFF);
        add_directed();
        add_random(250);
        drain();

        send_idle_pct = 66;
        recv_idle_pct = 11;
        write_reg(REG_MEAN, 32'h8000_0000);
        write_reg(REG_STD, 32'd0);
        add_random(250);
        drain();

        write_reg(REG_MEAN, $urandom);
        write_reg(REG_STD, $urandom_range(32'h00FF_FFFF));
        add_directed();
        hold_left = 600;
        add_random(250);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MEAN, 32'hFFF0_0000);
        write_reg(REG_STD, 32'd200000);
        hold_left = 800;
        add_random(350);
        drain();

        if (mismatches == 0 && expected_samples.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
